// ===== rtl/tapm_pkg.sv =====
// Shared types and constants for the tilt-angle PID motor duty block.
// Holds the config record, queue item, state enums and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package tapm_pkg;

  localparam int AXIS_W     = 16;
  localparam int ANGLE_W    = 17;
  localparam int ERR_W      = 18;
  localparam int CORD_W     = 28;
  localparam int ACC_W      = 27;
  localparam int TAB_IDX_W  = 5;
  localparam int TAB_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int INTEG_W    = 32;
  localparam int SUM_W      = 48;
  localparam int SCALE_BITS = 23;
  localparam int RECIP_W    = 24;
  localparam int RECIP_SH   = 30;
  localparam int QDEPTH     = 2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE    = 3'd5;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd46080;
  localparam logic signed [ACC_W-1:0]   HALF_TURN   = 27'sd11796480;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN   = 32'sh8000_0000;
  // 100 * 65536: percent scale times the Q.16 fraction of the gain sum
  localparam logic signed [SUM_W-1:0]   SCALE_DEN   = 48'sd6553600;
  // ceil(2^30 / 100): exact floor(q / 100) for every q below 14128181
  localparam logic [RECIP_W-1:0]        RECIP_100   = 24'd10737419;

  typedef struct packed {
    logic [15:0]               prop_gain;
    logic [15:0]               integ_gain;
    logic [15:0]               deriv_gain;
    logic signed [ANGLE_W-1:0] target_angle;
    logic [15:0]               step_time;
    logic [9:0]                step_rate;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [ANGLE_W-1:0] angle;
  } angle_item_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_RUN,
    FR_DONE
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_INTEG,
    BK_MUL2,
    BK_SUM,
    BK_SCALE,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [TAB_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tapm_cordic.sv =====
// Front end: accepts accelerometer samples and finds atan2(-y, z) in degrees
// with an iterative vectoring CORDIC, one micro-rotation per cycle.
// Depends on tapm_pkg.
`timescale 1ns / 1ps

module tapm_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tapm_pkg::AXIS_W-1:0]   accel_y,
  input  logic signed [tapm_pkg::AXIS_W-1:0]   accel_z,
  output tapm_pkg::angle_item_t                push,
  input  logic                                 push_ready
);
  import tapm_pkg::*;

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  front_state_t state, state_next;

  logic [SW-1:0]             step;
  logic signed [CORD_W-1:0]  x, y, x0, y0, x_sh, y_sh;
  logic signed [ACC_W-1:0]   acc, tab_ang;
  logic                      zero_vec, rot_cw, last_step;
  logic signed [ACC_W:0]     acc_rnd;
  logic signed [ACC_W-8:0]   acc_q;
  logic signed [ANGLE_W-1:0] angle;

  assign x0 = {{(CORD_W-AXIS_W-8){accel_z[AXIS_W-1]}}, accel_z, 8'd0};
  assign y0 = -{{(CORD_W-AXIS_W-8){accel_y[AXIS_W-1]}}, accel_y, 8'd0};

  assign x_sh      = x >>> step;
  assign y_sh      = y >>> step;
  assign rot_cw    = !y[CORD_W-1] && (y != '0);
  assign tab_ang   = ACC_W'(atan_deg(TAB_IDX_W'(step)));
  assign last_step = (step == SW'(CORDIC_STEPS - 1));

  // Round to Q8.8, then clamp
  assign acc_rnd = {acc[ACC_W-1], acc} + (ACC_W+1)'(128);
  assign acc_q   = acc_rnd[ACC_W:8];

  always_comb begin
    if (zero_vec) begin
      angle = '0;
    end else if (acc_q > ANGLE_LIMIT) begin
      angle = ANGLE_LIMIT;
    end else if (acc_q < -ANGLE_LIMIT) begin
      angle = -ANGLE_LIMIT;
    end else begin
      angle = acc_q[ANGLE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (in_valid) state_next = FR_RUN;
      FR_RUN:  if (last_step) state_next = FR_DONE;
      FR_DONE: if (push_ready) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == FR_IDLE);
    push.valid  = (state == FR_DONE);
    push.angle  = angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      zero_vec <= (accel_y == '0) && (accel_z == '0);
      step     <= '0;
      // Left half plane: pre-rotate by 180 degrees
      if (accel_z[AXIS_W-1]) begin
        acc <= y0[CORD_W-1] ? -HALF_TURN : HALF_TURN;
        x   <= -x0;
        y   <= -y0;
      end else begin
        acc <= '0;
        x   <= x0;
        y   <= y0;
      end
    end else if (state == FR_RUN) begin
      x    <= rot_cw ? x + y_sh : x - y_sh;
      y    <= rot_cw ? y - x_sh : y + x_sh;
      acc  <= rot_cw ? acc + tab_ang : acc - tab_ang;
      step <= step + SW'(1);
    end
  end

endmodule

// ===== rtl/tapm_fifo.sv =====
// Short angle queue between the CORDIC front end and the PID back end.
// Flop-based, first-word fall-through. Depends on tapm_pkg.
`timescale 1ns / 1ps

module tapm_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tapm_pkg::angle_item_t push,
  output logic                  push_ready,
  output tapm_pkg::angle_item_t head,
  input  logic                  pop
);
  import tapm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [ANGLE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic wr, rd;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.angle = mem[rptr];
  assign wr = push.valid && push_ready;
  assign rd = pop && head.valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= push.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      unique case ({wr, rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        2'b11:   count <= count;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tapm_pid.sv =====
// Back end: PID terms, saturating integral, duty scaling and the output register.
// Sequenced per angle through IDLE, MUL1, INTEG, MUL2, SUM, SCALE, DIV and OUT. Depends on tapm_pkg.
`timescale 1ns / 1ps

module tapm_pid #(
  parameter int DUTY_MAX = 8191
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tapm_pkg::cfg_t                        cfg,
  input  tapm_pkg::angle_item_t                 head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tapm_pkg::ANGLE_W-1:0]   tilt_angle,
  output logic [$clog2(DUTY_MAX+1)-1:0]         motor_power,
  output logic [$clog2(DUTY_MAX+1)-1:0]         pwm_compare,
  output logic                                  integral_saturated
);
  import tapm_pkg::*;

  localparam int PW = $clog2(DUTY_MAX + 1);

  back_state_t state, state_next;

  logic signed [ANGLE_W-1:0] angle_r;
  logic signed [ERR_W-1:0]   err, err_c, prev_err;
  logic signed [ERR_W:0]     diff, diff_c;
  logic signed [34:0]        prod_p, prod_i;
  logic signed [29:0]        rate;
  logic signed [INTEG_W-1:0] integral, integ_sat;
  logic signed [INTEG_W:0]   integ_sum;
  logic                      sat_r;
  logic signed [48:0]        ig_prod;
  logic signed [46:0]        dr_prod;
  logic signed [SUM_W-1:0]   sum;
  logic                      clamp_lo, clamp_hi;
  logic [SCALE_BITS+PW-1:0]  sd;
  logic [RECIP_SH+PW-1:0]    qm;
  logic [PW-1:0]             power;
  logic                      out_load;

  assign err_c  = {cfg.target_angle[ANGLE_W-1], cfg.target_angle}
                - {head.angle[ANGLE_W-1], head.angle};
  assign diff_c = {err_c[ERR_W-1], err_c} - {prev_err[ERR_W-1], prev_err};

  assign integ_sum = {integral[INTEG_W-1], integral}
                   + {{6{prod_i[34]}}, prod_i[34:8]};

  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (clamp_lo) begin
      power = '0;
    end else if (clamp_hi) begin
      power = PW'(DUTY_MAX);
    end else begin
      power = PW'(qm[RECIP_SH+PW-1:RECIP_SH]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (head.valid) state_next = BK_MUL1;
      BK_MUL1:  state_next = BK_INTEG;
      BK_INTEG: state_next = BK_MUL2;
      BK_MUL2:  state_next = BK_SUM;
      BK_SUM:   state_next = BK_SCALE;
      BK_SCALE: state_next = BK_DIV;
      BK_DIV:   state_next = BK_OUT;
      BK_OUT:   if (!out_valid || out_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == BK_IDLE);
    out_load = (state == BK_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      integral  <= '0;
      prev_err  <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == BK_INTEG) begin
        integral <= integ_sat;
        prev_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        angle_r <= head.angle;
        err     <= err_c;
        diff    <= diff_c;
      end
      BK_MUL1: begin
        prod_p <= $signed({1'b0, cfg.prop_gain}) * err;
        prod_i <= $signed({1'b0, cfg.step_time}) * err;
        rate   <= $signed({1'b0, cfg.step_rate}) * diff;
      end
      BK_INTEG: begin
        sat_r <= (integ_sat == INTEG_MAX) || (integ_sat == INTEG_MIN);
      end
      BK_MUL2: begin
        ig_prod <= $signed({1'b0, cfg.integ_gain}) * integral;
        dr_prod <= $signed({1'b0, cfg.deriv_gain}) * rate;
      end
      BK_SUM: begin
        sum <= {{13{prod_p[34]}}, prod_p}
             + {{7{ig_prod[48]}}, ig_prod[48:8]}
             + {dr_prod[46], dr_prod};
      end
      BK_SCALE: begin
        clamp_lo <= sum[SUM_W-1] || (sum == '0);
        clamp_hi <= !sum[SUM_W-1] && (sum >= SCALE_DEN);
        sd       <= sum[SCALE_BITS-1:0] * PW'(DUTY_MAX);
      end
      BK_DIV: begin
        qm <= sd[SCALE_BITS+PW-1:16] * RECIP_100;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tilt_angle         <= angle_r;
      motor_power        <= power;
      pwm_compare        <= PW'(DUTY_MAX) - power;
      integral_saturated <= sat_r;
    end
  end

endmodule

// ===== rtl/tilt_angle_pid_motor_duty.sv =====
// Top level of the tilt-angle PID motor duty block: config registers and the
// CORDIC front end, angle queue and PID back end. Depends on tapm_pkg,
// tapm_cordic, tapm_fifo and tapm_pid.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_ready  | accel_y, accel_z
//   output  | out_valid/ out_ready | tilt_angle, motor_power, pwm_compare,
//           |                      | integral_saturated
//   config  | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// The front end takes a new sample only after it has pushed the last angle into the queue:
// one micro-rotation per cycle in the shared CORDIC shift-add unit sets that pace.
// The back end takes one angle at a time through its states; with the queue empty and the
// output free, a sample passes the CORDIC, the queue, the PID states and the output register.
// Synchronous reset clears config to defaults, integral and previous error to zero.
// A stalled output holds the back end; the queue lets the front end keep working.
`timescale 1ns / 1ps

module tilt_angle_pid_motor_duty #(
  parameter int CORDIC_STEPS = 16,
  parameter int DUTY_MAX     = 8191
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tapm_pkg::AXIS_W-1:0]     accel_y,
  input  logic signed [tapm_pkg::AXIS_W-1:0]     accel_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tapm_pkg::ANGLE_W-1:0]    tilt_angle,
  output logic [$clog2(DUTY_MAX+1)-1:0]          motor_power,
  output logic [$clog2(DUTY_MAX+1)-1:0]          pwm_compare,
  output logic                                   integral_saturated,
  input  logic                                   cfg_write,
  input  logic [tapm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tapm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import tapm_pkg::*;

  cfg_t        cfg;
  angle_item_t push, head;
  logic        push_ready, pop;

  // Config registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= 16'd1280;
      cfg.integ_gain   <= 16'd256;
      cfg.deriv_gain   <= 16'd128;
      cfg.target_angle <= '0;
      cfg.step_time    <= 16'd655;
      cfg.step_rate    <= 10'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[15:0];
        REG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data[15:0];
        REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[15:0];
        REG_TARGET_ANGLE: cfg.target_angle <= cfg_data[ANGLE_W-1:0];
        REG_STEP_TIME:    cfg.step_time    <= cfg_data[15:0];
        REG_STEP_RATE:    cfg.step_rate    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accept a sample, iterate the CORDIC, push the angle
  tapm_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .push       (push),
    .push_ready (push_ready)
  );

  // Decouple the two halves so each can stall on its own
  tapm_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // Back end: PID arithmetic and the output register
  tapm_pid #(
    .DUTY_MAX (DUTY_MAX)
  ) u_pid (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .tilt_angle         (tilt_angle),
    .motor_power        (motor_power),
    .pwm_compare        (pwm_compare),
    .integral_saturated (integral_saturated)
  );

endmodule

// ===== rtl/tapm_checker.sv =====
// Port-level checks for tilt_angle_pid_motor_duty, attached with bind.
// Depends on tapm_pkg and the top level.
`timescale 1ns / 1ps

module tapm_checker #(
  parameter int DUTY_MAX = 8191
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [tapm_pkg::ANGLE_W-1:0]  tilt_angle,
  input logic [$clog2(DUTY_MAX+1)-1:0]        motor_power,
  input logic [$clog2(DUTY_MAX+1)-1:0]        pwm_compare
);
  import tapm_pkg::*;

  localparam int PW = $clog2(DUTY_MAX + 1);

  a_duty_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, motor_power} + {1'b0, pwm_compare}) == (PW+1)'(DUTY_MAX))
    else $error("pwm_compare does not complement motor_power");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_power <= PW'(DUTY_MAX))
    else $error("motor_power above full scale");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tilt_angle <= ANGLE_LIMIT) && (tilt_angle >= -ANGLE_LIMIT))
    else $error("tilt_angle outside clamp range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tilt_angle) && $stable(motor_power))
    else $error("stalled output transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind tilt_angle_pid_motor_duty tapm_checker #(
  .DUTY_MAX (DUTY_MAX)
) u_tapm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .tilt_angle  (tilt_angle),
  .motor_power (motor_power),
  .pwm_compare (pwm_compare)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tilt_angle_pid_motor_duty: sends accelerometer samples, predicts
// angle, power, compare value and saturation flag for each, and checks every output transaction.
// Depends on tapm_pkg and the RTL top level only.

module tb_top;
  import tapm_pkg::*;

  localparam int CORDIC_ITERS = 16;
  localparam int DUTY_FULL    = 8191;
  localparam int PWR_W        = $clog2(DUTY_FULL + 1);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 40;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [AXIS_W-1:0] AX_MIN  = 16'sh8000;
  localparam logic signed [AXIS_W-1:0] AX_MAX  = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] AX_ZERO = 16'sd0;
  localparam logic signed [AXIS_W-1:0] AX_ONE  = 16'sd1;
  localparam logic signed [AXIS_W-1:0] AX_NEG1 = -16'sd1;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic [PWR_W-1:0]          power;
    logic [PWR_W-1:0]          compare;
    logic                      sat;
  } duty_result_t;

  // DUT ports; every input is known from time zero
  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic signed [AXIS_W-1:0]  accel_y   = '0;
  logic signed [AXIS_W-1:0]  accel_z   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] tilt_angle;
  logic [PWR_W-1:0]          motor_power;
  logic [PWR_W-1:0]          pwm_compare;
  logic                      integral_saturated;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;

  // Predictor state: a shadow of the registers plus the PID memory
  cfg_t         shadow_cfg;
  int           integ_q16;
  longint       prev_err;
  logic         last_sat;
  duty_result_t expected_duty[$];

  int  bad_count    = 0;
  int  cycle_count  = 0;
  int  stall_left   = 0;
  bit  tx_gaps_on   = 1'b1;
  bit  rx_stalls_on = 1'b1;

  tilt_angle_pid_motor_duty u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .accel_y            (accel_y),
    .accel_z            (accel_z),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .tilt_angle         (tilt_angle),
    .motor_power        (motor_power),
    .pwm_compare        (pwm_compare),
    .integral_saturated (integral_saturated),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // atan(2^-i) in degrees, Q.16
  function automatic longint atan_q16(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC on (z, -y); >>> on longint floors, as the hardware shifts do.
  function automatic logic signed [ANGLE_W-1:0] tilt_deg(input logic signed [AXIS_W-1:0] ay,
                                                         input logic signed [AXIS_W-1:0] az);
    longint x, y, acc, nx, ny;
    x   = longint'(az) * 256;
    y   = -longint'(ay) * 256;
    acc = 0;
    if (ay == 0 && az == 0) return '0;
    // Fold the left half plane onto the right with a half turn.
    if (x < 0) begin
      acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x   = -x;
      y   = -y;
    end
    for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
      if (y > 0) begin
        nx  = x + (y >>> i);
        ny  = y - (x >>> i);
        acc = acc + atan_q16(i);
      end else begin
        nx  = x - (y >>> i);
        ny  = y + (x >>> i);
        acc = acc - atan_q16(i);
      end
      x = nx;
      y = ny;
    end
    acc = (acc + 128) >>> 8;
    if (acc > longint'(ANGLE_LIMIT))  acc = longint'(ANGLE_LIMIT);
    if (acc < -longint'(ANGLE_LIMIT)) acc = -longint'(ANGLE_LIMIT);
    return ANGLE_W'(acc);
  endfunction

  // Advance the PID memory by one sample and return the duty it produces.
  function automatic duty_result_t predict_duty(input logic signed [AXIS_W-1:0] ay,
                                                input logic signed [AXIS_W-1:0] az);
    duty_result_t r;
    longint err, integ, rate, sum, power;
    r.angle = tilt_deg(ay, az);
    err     = longint'($signed(shadow_cfg.target_angle)) - longint'(r.angle);
    integ   = longint'(integ_q16) + ((err * longint'(shadow_cfg.step_time)) >>> 8);
    if (integ > longint'(INTEG_MAX)) integ = longint'(INTEG_MAX);
    if (integ < longint'(INTEG_MIN)) integ = longint'(INTEG_MIN);
    r.sat   = (integ == longint'(INTEG_MAX)) || (integ == longint'(INTEG_MIN));
    rate    = (err - prev_err) * longint'(shadow_cfg.step_rate);
    sum     = longint'(shadow_cfg.prop_gain) * err
            + ((longint'(shadow_cfg.integ_gain) * integ) >>> 8)
            + longint'(shadow_cfg.deriv_gain) * rate;
    // Signed division truncates toward zero.
    power   = (sum * DUTY_FULL) / (longint'(100) * 65536);
    if (power < 0) power = 0;
    if (power > DUTY_FULL) power = DUTY_FULL;
    r.power   = PWR_W'(power);
    r.compare = PWR_W'(DUTY_FULL - power);
    integ_q16 = int'(integ);
    prev_err  = err;
    last_sat  = r.sat;
    return r;
  endfunction

  function automatic void shadow_apply(input logic [CFG_IDX_W-1:0]  idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PROP_GAIN:    shadow_cfg.prop_gain    = data[15:0];
      REG_INTEG_GAIN:   shadow_cfg.integ_gain   = data[15:0];
      REG_DERIV_GAIN:   shadow_cfg.deriv_gain   = data[15:0];
      REG_TARGET_ANGLE: shadow_cfg.target_angle = data[ANGLE_W-1:0];
      REG_STEP_TIME:    shadow_cfg.step_time    = data[15:0];
      REG_STEP_RATE:    shadow_cfg.step_rate    = data[9:0];
      default: ;  // spare index: nothing behind it
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [AXIS_W-1:0] rand_axis();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 4))
        0:       return AX_MIN;
        1:       return AX_MAX;
        2:       return AX_ZERO;
        3:       return AX_ONE;
        default: return AX_NEG1;
      endcase
    end
    if (roll < 30) return AXIS_W'($urandom_range(0, 65535));
    if (roll < 50) return AXIS_W'(int'($urandom_range(0, 127)) - 64);
    // typical reading of a sensor within about 1 g
    return AXIS_W'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return CFG_DATA_W'(16'hFFFF);
    if (roll < 60) return CFG_DATA_W'($urandom_range(0, 1024));
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_target();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return CFG_DATA_W'(ANGLE_LIMIT);
    if (roll < 16) return CFG_DATA_W'(-ANGLE_LIMIT);
    return CFG_DATA_W'(int'($urandom_range(0, 92160)) - 46080);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_in_range(input int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return CFG_DATA_W'(1);
    if (roll < 20) return CFG_DATA_W'(hi);
    return CFG_DATA_W'($urandom_range(1, hi));
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Hold valid and payload until the transaction is taken, then log its prediction.
  task automatic send_sample(input logic signed [AXIS_W-1:0] ay,
                             input logic signed [AXIS_W-1:0] az);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_y  <= ay;
    accel_z  <= az;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_duty.push_back(predict_duty(ay, az));
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_duty.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_apply(idx, data);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the result check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!rx_stalls_on || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    duty_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_duty.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("cycle %0d: output transaction with nothing expected, angle %0d power %0d",
                   cycle_count, tilt_angle, motor_power);
      end else begin
        want = expected_duty.pop_front();
        if (tilt_angle !== want.angle || motor_power !== want.power ||
            pwm_compare !== want.compare || integral_saturated !== want.sat) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS) begin
            $write("cycle %0d: mismatch (expected/actual) angle %0d/%0d power %0d/%0d ",
                   cycle_count, want.angle, tilt_angle, want.power, motor_power);
            $display("compare %0d/%0d saturated %0b/%0b", want.compare, pwm_compare,
                     want.sat, integral_saturated);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Axis extremes and the geometric corners under the power-up gains:
  // zero vector, straight down, both sides of the half-turn fold, tiny vectors.
  task automatic test_reset_samples();
    send_sample(AX_ZERO, AX_ZERO);
    send_sample(AX_ZERO, AX_MIN);
    send_sample(AX_ZERO, AX_MAX);
    send_sample(AX_MAX,  AX_ZERO);
    send_sample(AX_MIN,  AX_ZERO);
    send_sample(AX_MAX,  AX_MAX);
    send_sample(AX_MIN,  AX_MIN);
    send_sample(AX_MIN,  AX_MAX);
    send_sample(AX_MAX,  AX_MIN);
    send_sample(AX_ONE,  AX_MIN);
    send_sample(AX_NEG1, AX_MIN);
    send_sample(AX_MIN,  AX_NEG1);
    send_sample(AX_NEG1, AX_NEG1);
    send_sample(AX_ONE,  AX_ONE);
  endtask

  // Every register at its extremes, zero step time and rate, and writes to spare indexes.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_PROP_GAIN,    CFG_DATA_W'(16'hFFFF));
    write_reg(REG_INTEG_GAIN,   '0);
    write_reg(REG_DERIV_GAIN,   CFG_DATA_W'(16'hFFFF));
    write_reg(REG_TARGET_ANGLE, CFG_DATA_W'(-ANGLE_LIMIT));
    write_reg(REG_STEP_TIME,    '0);
    write_reg(REG_STEP_RATE,    '0);
    send_sample(AX_ZERO, AX_MAX);
    send_sample(AX_MAX,  AX_ONE);
    send_sample(AX_MIN,  AX_ONE);
    send_sample(AX_ZERO, AX_MIN);

    // These must leave every register untouched.
    wait_idle();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, CFG_DATA_W'(17'h15555));
    send_sample(AX_ONE, AX_MAX);
    send_sample(AX_MIN, AX_MIN);

    wait_idle();
    write_reg(REG_PROP_GAIN,    '0);
    write_reg(REG_INTEG_GAIN,   CFG_DATA_W'(16'hFFFF));
    write_reg(REG_DERIV_GAIN,   '0);
    write_reg(REG_TARGET_ANGLE, CFG_DATA_W'(ANGLE_LIMIT));
    write_reg(REG_STEP_TIME,    CFG_DATA_W'(16'hFFFF));
    write_reg(REG_STEP_RATE,    CFG_DATA_W'(1000));
    send_sample(AX_MAX,  AX_MAX);
    send_sample(AX_NEG1, AX_ONE);
    send_sample(AX_MIN,  AX_MAX);
    send_sample(AX_ZERO, AX_ZERO);
  endtask

  // Push the integral into its upper limit, then all the way down into the lower one.
  task automatic test_integral_saturation();
    int sent, hits;
    wait_idle();
    write_reg(REG_PROP_GAIN,    CFG_DATA_W'(256));
    write_reg(REG_INTEG_GAIN,   CFG_DATA_W'(256));
    write_reg(REG_DERIV_GAIN,   '0);
    write_reg(REG_STEP_TIME,    CFG_DATA_W'(16'hFFFF));
    write_reg(REG_STEP_RATE,    CFG_DATA_W'(1));
    write_reg(REG_TARGET_ANGLE, CFG_DATA_W'(ANGLE_LIMIT));

    // Samples near -180 degrees give the largest positive error.
    sent = 0;
    hits = 0;
    while (hits < 4 && sent < 250) begin
      send_sample(AXIS_W'($urandom_range(1, 3000)), AX_MIN + AXIS_W'($urandom_range(0, 16384)));
      if (last_sat) hits++;
      sent++;
    end

    wait_idle();
    write_reg(REG_TARGET_ANGLE, CFG_DATA_W'(-ANGLE_LIMIT));
    // Samples near +180 degrees now drive the error hard negative.
    sent = 0;
    hits = 0;
    while (hits < 4 && sent < 400) begin
      send_sample(AXIS_W'(-int'($urandom_range(0, 3000))),
                  AX_MIN + AXIS_W'($urandom_range(0, 16384)));
      if (last_sat) hits++;
      sent++;
    end
  endtask

  // Random register settings per phase, random samples, idling switched per phase.
  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      write_reg(REG_PROP_GAIN,    rand_gain());
      write_reg(REG_INTEG_GAIN,   rand_gain());
      write_reg(REG_DERIV_GAIN,   rand_gain());
      write_reg(REG_TARGET_ANGLE, rand_target());
      write_reg(REG_STEP_TIME,    rand_in_range(65535));
      write_reg(REG_STEP_RATE,    rand_in_range(1000));
      // Leave some phases free of idling on one side or both.
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < per_phase; n++)
        send_sample(rand_axis(), rand_axis());
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Power-up register values and cleared PID memory.
    shadow_cfg.prop_gain    = 16'd1280;
    shadow_cfg.integ_gain   = 16'd256;
    shadow_cfg.deriv_gain   = 16'd128;
    shadow_cfg.target_angle = '0;
    shadow_cfg.step_time    = 16'd655;
    shadow_cfg.step_rate    = 10'd100;
    integ_q16 = 0;
    prev_err  = 0;
    last_sat  = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_samples();
    test_register_extremes();
    test_integral_saturation();
    test_random_settings(5, 35);

    wait_idle();
    if (bad_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
